// ===== hw/rtl/lmfs_pkg.sv =====
// Package for the LED matrix frame serializer: request and result types, codes and constants.
package lmfs_pkg;

	localparam int unsigned GRID_COUNT_DEF  = 5;
	localparam int unsigned ROW_COUNT_DEF   = 10;
	localparam int unsigned BLANK_BYTES_DEF = 80;

	localparam logic [7:0] ADDR_BYTE = 8'hC0;
	localparam logic [7:0] LEVEL_MAX = 8'hFF;

	typedef enum logic [2:0] {
		OP_TICK       = 3'd0,
		OP_WRITE_GRID = 3'd1,
		OP_SEND_CMD   = 3'd2,
		OP_SEND_FRAME = 3'd3,
		OP_SEND_BLANK = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_CMD   = 2'd1,
		KIND_FRAME = 2'd2,
		KIND_BLANK = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CLK_HIGH  = 2'd0,
		CLK_LOW   = 2'd1,
		CLK_PULSE = 2'd2
	} clk_mode_t;

	typedef struct packed {
		logic [2:0] operation;
		logic [2:0] grid_index;
		logic [7:0] segment_pattern;
		logic [7:0] command_byte;
	} req_t;

	typedef struct packed {
		logic [1:0] clock_mode;
		logic       data_level;
		logic       slot_valid;
		logic       last_slot;
		logic       send_rejected;
		logic       busy_res;
	} res_t;

endpackage

// ===== hw/rtl/led_matrix_frame_serializer_unit.sv =====
// Top level of the LED matrix frame serializer: pattern store, slot sequencer and result register.
// The result of each accepted request is registered in the output register.
// Throughput: one request per cycle unless the held result is stalled; slot counter steps per tick,
// grid counter per frame data byte, row counter per grid wrap. The output register accepts a new
// request in the same cycle its result is taken. Reset (arst_n low, asynchronous): patterns,
// counters, held command and brightness clear to zero, no transfer active, output register empty.
module led_matrix_frame_serializer_unit #(
	parameter int unsigned GRID_COUNT  = lmfs_pkg::GRID_COUNT_DEF,
	parameter int unsigned ROW_COUNT   = lmfs_pkg::ROW_COUNT_DEF,
	parameter int unsigned BLANK_BYTES = lmfs_pkg::BLANK_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  lmfs_pkg::req_t req_data,
	output logic           res_valid,
	input  logic           res_stall,
	output lmfs_pkg::res_t res_data,
	input  logic           cfg_we,
	input  logic [6:0]     cfg_wdata
);
	import lmfs_pkg::*;

	localparam int unsigned FRAME_BYTES = 1 + GRID_COUNT * ROW_COUNT;
	localparam int unsigned BLANK_TOTAL = 1 + BLANK_BYTES;
	localparam int unsigned MAX_BYTES   = (FRAME_BYTES > BLANK_TOTAL) ? FRAME_BYTES : BLANK_TOTAL;
	localparam int unsigned SW = $clog2(8 * MAX_BYTES + 6);
	localparam int unsigned GW = (GRID_COUNT > 1) ? $clog2(GRID_COUNT) : 1;
	localparam int unsigned RW = $clog2(ROW_COUNT + 1);
	localparam logic [SW-1:0] CMD_BITS   = SW'(8);
	localparam logic [SW-1:0] FRAME_BITS = SW'(8 * FRAME_BYTES);
	localparam logic [SW-1:0] BLANK_BITS = SW'(8 * BLANK_TOTAL);

	logic [7:0]    grid_q [GRID_COUNT];
	kind_t         kind_q;
	logic [SW-1:0] slot_q;
	logic [7:0]    cmd_q;
	logic          active_q;
	logic [6:0]    bright_q;
	logic [GW-1:0] gsel_q;
	logic [RW-1:0] row_q;
	res_t          res_s1;
	logic          res_valid_q;

	logic          accept;
	logic [SW-1:0] nbits;
	logic [SW-1:0] b;
	logic [SW-1:0] t;
	logic [SW-4:0] byte_idx;
	logic [2:0]    bit_pos;
	logic [9:0]    prod;
	logic [7:0]    level;
	logic [7:0]    pat;
	logic [7:0]    cur_byte;
	logic [2:0]    seg_bit;
	logic          row_on;
	logic          is_tick;
	logic          is_send;
	logic          in_data;
	logic          step_grid;
	res_t          res_d;

	assign req_stall = res_valid_q && res_stall;
	assign accept    = req_valid && !req_stall;
	assign res_valid = res_valid_q;
	assign res_data  = res_s1;

	assign is_tick = (req_data.operation == OP_TICK);
	assign is_send = (req_data.operation == OP_SEND_CMD) || (req_data.operation == OP_SEND_FRAME)
		|| (req_data.operation == OP_SEND_BLANK);

	always_comb begin
		unique case (kind_q)
			KIND_CMD:   nbits = CMD_BITS;
			KIND_FRAME: nbits = FRAME_BITS;
			default:    nbits = BLANK_BITS;
		endcase
	end

	assign b        = slot_q - SW'(2);
	assign t        = slot_q - SW'(2) - nbits;
	assign byte_idx = b[SW-1:3];
	assign bit_pos  = b[2:0];
	assign in_data  = (slot_q >= SW'(2)) && (slot_q < SW'(2) + nbits);

	assign prod  = 10'(bright_q) * 10'd5;
	assign level = (prod[9:1] > 9'(LEVEL_MAX)) ? LEVEL_MAX : prod[8:1];
	assign pat   = grid_q[gsel_q];

	always_comb begin
		row_on  = 1'b0;
		seg_bit = 3'd0;
		if (row_q <= RW'(3)) begin
			row_on  = 1'b1;
			seg_bit = row_q[2:0];
		end else if (row_q >= RW'(6) && row_q <= RW'(9)) begin
			row_on  = 1'b1;
			seg_bit = 3'(row_q - RW'(2));
		end
	end

	always_comb begin
		if (kind_q == KIND_CMD) begin
			cur_byte = cmd_q;
		end else if (byte_idx == '0) begin
			cur_byte = ADDR_BYTE;
		end else if (kind_q != KIND_FRAME) begin
			cur_byte = 8'd0;
		end else begin
			cur_byte = (row_on && pat[seg_bit]) ? level : 8'd0;
		end
	end

	assign step_grid = accept && is_tick && active_q && in_data && (bit_pos == 3'd7)
		&& (kind_q == KIND_FRAME) && (byte_idx != '0);

	always_comb begin
		res_d               = '0;
		res_d.clock_mode    = CLK_HIGH;
		res_d.data_level    = 1'b1;
		res_d.busy_res      = active_q;
		if (is_tick && active_q) begin
			res_d.slot_valid = 1'b1;
			if (slot_q < SW'(2)) begin
				res_d.clock_mode = (slot_q == '0) ? CLK_HIGH : CLK_LOW;
				res_d.data_level = 1'b0;
			end else if (in_data) begin
				res_d.clock_mode = CLK_PULSE;
				res_d.data_level = cur_byte[3'd7 - bit_pos];
			end else begin
				res_d.clock_mode = (t == '0) ? CLK_LOW : CLK_HIGH;
				res_d.data_level = (t == SW'(2));
				res_d.last_slot  = (t >= SW'(2));
				res_d.busy_res   = (t < SW'(2));
			end
		end else if (is_send) begin
			res_d.send_rejected = active_q;
			res_d.busy_res      = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GRID_COUNT; i++) begin
				grid_q[i] <= 8'd0;
			end
			kind_q      <= KIND_NONE;
			slot_q      <= '0;
			cmd_q       <= 8'd0;
			active_q    <= 1'b0;
			bright_q    <= 7'd0;
			gsel_q      <= '0;
			row_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				bright_q <= cfg_wdata;
			end
			if (accept) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (step_grid) begin
				if (gsel_q == GW'(GRID_COUNT - 1)) begin
					gsel_q <= '0;
					row_q  <= row_q + RW'(1);
				end else begin
					gsel_q <= gsel_q + GW'(1);
				end
			end
			if (accept) begin
				if (is_tick) begin
					if (active_q) begin
						if (res_d.last_slot) begin
							active_q <= 1'b0;
							kind_q   <= KIND_NONE;
							slot_q   <= '0;
						end else begin
							slot_q <= slot_q + SW'(1);
						end
					end
				end else if (req_data.operation == OP_WRITE_GRID) begin
					if (32'(req_data.grid_index) < GRID_COUNT) begin
						grid_q[GW'(req_data.grid_index)] <= req_data.segment_pattern;
					end
				end else if (is_send && !active_q) begin
					active_q <= 1'b1;
					slot_q   <= '0;
					gsel_q   <= '0;
					row_q    <= '0;
					if (req_data.operation == OP_SEND_CMD) begin
						kind_q <= KIND_CMD;
						cmd_q  <= req_data.command_byte;
					end else if (req_data.operation == OP_SEND_FRAME) begin
						kind_q <= KIND_FRAME;
					end else begin
						kind_q <= KIND_BLANK;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
		end
	end

endmodule

// ===== tb/sv/led_matrix_frame_serializer_checker.sv =====
// Checker for the LED matrix frame serializer: watches both channels, predicts slots, compares.
`timescale 1ns / 100ps
module led_matrix_frame_serializer_checker #(
	parameter int unsigned GRID_COUNT  = lmfs_pkg::GRID_COUNT_DEF,
	parameter int unsigned ROW_COUNT   = lmfs_pkg::ROW_COUNT_DEF,
	parameter int unsigned BLANK_BYTES = lmfs_pkg::BLANK_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  lmfs_pkg::req_t req_data,
	input  logic           res_valid,
	input  logic           res_stall,
	input  lmfs_pkg::res_t res_data,
	input  logic           cfg_we,
	input  logic [6:0]     cfg_wdata,
	output int             mismatches,
	output int             pending,
	output int             slots_checked
);
	import lmfs_pkg::*;

	logic [7:0]  grid_pat [GRID_COUNT];
	kind_t       xfer_kind;
	int unsigned slot_no;
	logic [7:0]  held_cmd;
	logic        xfer_busy;
	logic [6:0]  bright;
	res_t        expected_slots [$];

	function automatic res_t next_slot(input req_t r);
		res_t        o;
		int unsigned nbits;
		int unsigned b;
		int unsigned idx;
		int unsigned row;
		int unsigned grid;
		int unsigned bitn;
		int unsigned t;
		int unsigned v;
		logic [7:0]  byt;
		o = '0;
		case (r.operation)
			OP_TICK: begin
				if (xfer_busy) begin
					if (xfer_kind == KIND_CMD)
						nbits = 8;
					else if (xfer_kind == KIND_FRAME)
						nbits = 8 * (1 + GRID_COUNT * ROW_COUNT);
					else
						nbits = 8 * (1 + BLANK_BYTES);
					o.slot_valid = 1'b1;
					if (slot_no < 2) begin
						o.clock_mode = (slot_no == 0) ? CLK_HIGH : CLK_LOW;
						o.data_level = 1'b0;
					end else if (slot_no < 2 + nbits) begin
						b   = slot_no - 2;
						idx = b / 8;
						v   = bright * 25 / 10;
						if (xfer_kind == KIND_CMD) begin
							byt = held_cmd;
						end else if (idx == 0) begin
							byt = ADDR_BYTE;
						end else if (xfer_kind != KIND_FRAME) begin
							byt = 8'h00;
						end else begin
							row  = (idx - 1) / GRID_COUNT;
							grid = (idx - 1) % GRID_COUNT;
							bitn = (row <= 3) ? row : row - 2;
							byt  = 8'h00;
							if ((row <= 3 || (row >= 6 && row <= 9)) && grid_pat[grid][bitn])
								byt = (v > LEVEL_MAX) ? LEVEL_MAX : v[7:0];
						end
						o.clock_mode = CLK_PULSE;
						o.data_level = byt[7 - (b % 8)];
					end else begin
						t = slot_no - 2 - nbits;
						o.clock_mode = (t == 0) ? CLK_LOW : CLK_HIGH;
						o.data_level = (t == 2);
						o.last_slot  = (t >= 2);
					end
					if (o.last_slot) begin
						xfer_busy = 1'b0;
						xfer_kind = KIND_NONE;
						slot_no   = 0;
					end else begin
						slot_no = slot_no + 1;
					end
				end
			end
			OP_WRITE_GRID: begin
				if (r.grid_index < GRID_COUNT)
					grid_pat[r.grid_index] = r.segment_pattern;
			end
			OP_SEND_CMD, OP_SEND_FRAME, OP_SEND_BLANK: begin
				if (xfer_busy) begin
					o.send_rejected = 1'b1;
				end else begin
					xfer_busy = 1'b1;
					slot_no   = 0;
					if (r.operation == OP_SEND_CMD) begin
						xfer_kind = KIND_CMD;
						held_cmd  = r.command_byte;
					end else begin
						xfer_kind = (r.operation == OP_SEND_FRAME) ? KIND_FRAME : KIND_BLANK;
					end
				end
			end
			default: ;
		endcase
		if (!o.slot_valid) begin
			o.clock_mode = CLK_HIGH;
			o.data_level = 1'b1;
			o.last_slot  = 1'b0;
		end
		o.busy_res = xfer_busy;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			for (int i = 0; i < GRID_COUNT; i++)
				grid_pat[i] = 8'h00;
			xfer_kind     = KIND_NONE;
			slot_no       = 0;
			held_cmd      = 8'h00;
			xfer_busy     = 1'b0;
			bright        = '0;
			expected_slots.delete();
			mismatches    = 0;
			pending       = 0;
			slots_checked = 0;
		end else begin
			if (res_valid && !res_stall) begin
				slots_checked++;
				if (expected_slots.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with no request outstanding: %p", $realtime, res_data);
				end else begin
					want = expected_slots.pop_front();
					if (res_data !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: slot mismatch, expected clk=%0d dat=%0d vld=%0d last=%0d ",
								"rej=%0d busy=%0d, got clk=%0d dat=%0d vld=%0d last=%0d rej=%0d busy=%0d"},
								$realtime, want.clock_mode, want.data_level, want.slot_valid,
								want.last_slot, want.send_rejected, want.busy_res,
								res_data.clock_mode, res_data.data_level, res_data.slot_valid,
								res_data.last_slot, res_data.send_rejected, res_data.busy_res);
					end
				end
			end
			if (cfg_we)
				bright = cfg_wdata;
			if (req_valid && !req_stall)
				expected_slots.push_back(next_slot(req_data));
			pending = expected_slots.size();
		end
	end

endmodule

// ===== tb/sv/led_matrix_frame_serializer_unit_tb.sv =====
// Testbench top for the LED matrix frame serializer: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module led_matrix_frame_serializer_unit_tb;
	import lmfs_pkg::*;

	localparam int unsigned IDLE_LIMIT  = 4000;
	localparam int unsigned PHASE_REQS  = 32;
	localparam int unsigned BLANK_TICKS = 40;

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_stall;
	req_t       req_data;
	logic       res_valid;
	logic       res_stall;
	res_t       res_data;
	logic       cfg_we;
	logic [6:0] cfg_wdata;

	int          mismatches;
	int          pending;
	int          slots_checked;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned reqs_sent;
	int unsigned quiet_cycles;
	int unsigned cmd_xfers;
	int unsigned frame_xfers;
	int unsigned blank_xfers;

	led_matrix_frame_serializer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	led_matrix_frame_serializer_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req_data      (req_data),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.res_data      (res_data),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.mismatches    (mismatches),
		.pending       (pending),
		.slots_checked (slots_checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			res_stall = ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (res_valid && !res_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	function automatic req_t make_req(input logic [2:0] op, input logic [2:0] gi,
		input logic [7:0] pat, input logic [7:0] cmd);
		req_t r;
		r.operation       = op;
		r.grid_index      = gi;
		r.segment_pattern = pat;
		r.command_byte    = cmd;
		return r;
	endfunction

	// Call at a falling edge; returns at the falling edge after acceptance.
	task automatic push_req(input req_t r);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req_data  = r;
		do
			@(posedge clk);
		while (req_stall);
		reqs_sent++;
		@(negedge clk);
	endtask

	task automatic drain;
		req_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic run_transfer(input op_t send_op);
		int unsigned ticks_left;
		int unsigned pick;
		case (send_op)
			OP_SEND_CMD: begin
				ticks_left = 5 + 8;
				cmd_xfers++;
			end
			OP_SEND_FRAME: begin
				ticks_left = 5 + 8 * (1 + GRID_COUNT_DEF * ROW_COUNT_DEF);
				frame_xfers++;
			end
			default: begin
				ticks_left = 5 + 8 * (1 + BLANK_BYTES_DEF);
				blank_xfers++;
			end
		endcase
		push_req(make_req(send_op, 3'($urandom_range(7)), 8'($urandom_range(255)),
			8'($urandom_range(255))));
		while (ticks_left > 0) begin
			pick = $urandom_range(99);
			if (pick < 88) begin
				push_req(make_req(OP_TICK, 3'($urandom_range(7)), 8'($urandom_range(255)),
					8'($urandom_range(255))));
				ticks_left--;
			end else if (pick < 94) begin
				push_req(make_req(OP_WRITE_GRID, 3'($urandom_range(7)), 8'($urandom_range(255)),
					8'($urandom_range(255))));
			end else if (pick < 97) begin
				push_req(make_req(3'($urandom_range(OP_SEND_BLANK, OP_SEND_CMD)),
					3'($urandom_range(7)), 8'($urandom_range(255)), 8'($urandom_range(255))));
			end else begin
				push_req(make_req(3'($urandom_range(7, OP_SEND_BLANK + 1)), 3'($urandom_range(7)),
					8'($urandom_range(255)), 8'($urandom_range(255))));
			end
		end
	endtask

	initial begin
		int unsigned idle_plan [4];
		int unsigned stall_plan [4];
		int unsigned bright_plan [4];
		op_t         first_send [4];
		int unsigned phase_start;
		int unsigned pick;
		idle_plan   = '{0, 52, 0, 13};
		stall_plan  = '{0, 0, 52, 13};
		bright_plan = '{127, 0, $urandom_range(99, 1), 100};
		first_send  = '{OP_SEND_FRAME, OP_SEND_CMD, OP_SEND_CMD, OP_SEND_CMD};
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req_data     = '0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		idle_pct     = 0;
		stall_pct    = 0;
		reqs_sent    = 0;
		quiet_cycles = 0;
		cmd_xfers    = 0;
		frame_xfers  = 0;
		blank_xfers  = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		push_req(make_req(OP_TICK, 3'h0, 8'h00, 8'h00));
		for (int op = OP_SEND_BLANK + 1; op <= 7; op++)
			push_req(make_req(3'(op), 3'h7, 8'hFF, 8'hFF));
		push_req(make_req(OP_WRITE_GRID, 3'h0, 8'hFF, 8'h00));
		push_req(make_req(OP_WRITE_GRID, 3'(GRID_COUNT_DEF - 1), 8'h00, 8'hFF));
		push_req(make_req(OP_WRITE_GRID, 3'(GRID_COUNT_DEF), 8'hAA, 8'h00));
		push_req(make_req(OP_WRITE_GRID, 3'h7, 8'h55, 8'h00));
		push_req(make_req(OP_SEND_CMD, 3'h0, 8'h00, 8'hFF));
		push_req(make_req(OP_SEND_CMD, 3'h7, 8'hFF, 8'h00));
		push_req(make_req(OP_SEND_FRAME, 3'h0, 8'h00, 8'h00));
		push_req(make_req(OP_SEND_BLANK, 3'h0, 8'h00, 8'h00));
		repeat (13)
			push_req(make_req(OP_TICK, 3'h0, 8'h00, 8'h00));

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			cfg_we    = 1'b1;
			cfg_wdata = 7'(bright_plan[ph]);
			@(negedge clk);
			cfg_we    = 1'b0;
			idle_pct  = idle_plan[ph];
			stall_pct = stall_plan[ph];
			phase_start = reqs_sent;
			for (int g = 0; g < GRID_COUNT_DEF; g++)
				push_req(make_req(OP_WRITE_GRID, 3'(g), 8'($urandom_range(255)),
					8'($urandom_range(255))));
			run_transfer(first_send[ph]);
			while (reqs_sent - phase_start < PHASE_REQS) begin
				repeat ($urandom_range(3)) begin
					pick = $urandom_range(2);
					if (pick == 0)
						push_req(make_req(OP_TICK, 3'($urandom_range(7)), 8'($urandom_range(255)),
							8'($urandom_range(255))));
					else if (pick == 1)
						push_req(make_req(OP_WRITE_GRID, 3'($urandom_range(7)),
							8'($urandom_range(255)), 8'($urandom_range(255))));
					else
						push_req(make_req(3'($urandom_range(7, OP_SEND_BLANK + 1)),
							3'($urandom_range(7)), 8'($urandom_range(255)), 8'($urandom_range(255))));
				end
				run_transfer(OP_SEND_CMD);
			end
		end

		push_req(make_req(OP_SEND_BLANK, 3'h0, 8'h00, 8'h00));
		blank_xfers++;
		repeat (BLANK_TICKS)
			push_req(make_req(OP_TICK, 3'($urandom_range(7)), 8'($urandom_range(255)),
				8'($urandom_range(255))));

		drain();
		repeat (4) @(posedge clk);
		$display("Ran %0d requests over four idle and stall mixes at brightness 127, 0, %0d and 100",
			reqs_sent, bright_plan[2]);
		$display("%0d command, %0d frame and %0d blank transfers started; %0d slots, %0d mismatches",
			cmd_xfers, frame_xfers, blank_xfers, slots_checked, mismatches);
		if (mismatches == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/lmfs_pkg.sv
hw/rtl/led_matrix_frame_serializer_unit.sv
tb/sv/led_matrix_frame_serializer_checker.sv
tb/sv/led_matrix_frame_serializer_unit_tb.sv
